// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file of this block.
// No dependencies; included by rdsc_checker.sv, which carries the assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check that is switched off while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Concurrent check that also covers the reset cycles.
`define ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) \
        else $error(msg);

`endif

// ----- rtl/rdsc_pkg.sv -----
// Shared types, constants and the digit glyph function of the radix converter.
// No dependencies; imported by the front end, the back end and the top level.
`timescale 1ns / 1ps

package rdsc_pkg;

    localparam int VALUE_BITS_DEF = 31;
    localparam int MAX_DIGITS_DEF = 32;
    localparam int BASE_W         = 8;
    localparam int RADIX_W        = 5;
    localparam int DIGIT_W        = 4;
    localparam int CHAR_W         = 8;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [BASE_W-1:0] RADIX_MIN = 8'd2;
    localparam logic [BASE_W-1:0] RADIX_MAX = 8'd16;
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_A    = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_NONE = 8'h00;

    typedef enum logic [1:0] {
        KIND_BAD,
        KIND_ZERO,
        KIND_CONV
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FETCH,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic               valid;
        t_kind              kind;
        logic [RADIX_W-1:0] radix;
    } t_cmd;

    function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] d_ext;
        d_ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
        if (d < 4'd10) begin
            glyph = CHAR_ZERO + d_ext;
        end else begin
            glyph = CHAR_A + d_ext - 8'd10;
        end
    endfunction

endpackage

// ----- rtl/rdsc_front.sv -----
// Front end: accepts conversion requests, classifies them and queues them.
// Depends on rdsc_pkg.
`timescale 1ns / 1ps

module rdsc_front #(
    parameter int VALUE_BITS = rdsc_pkg::VALUE_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [VALUE_BITS-1:0]     i_value,
    input  logic [rdsc_pkg::BASE_W-1:0] i_base,
    output logic                      o_busy,
    output rdsc_pkg::t_cmd            o_cmd,
    output logic [VALUE_BITS-1:0]     o_value,
    input  logic                      i_pop
);
    import rdsc_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [VALUE_BITS-1:0] r_val_q [QUEUE_DEPTH];
    t_kind                 r_kind_q [QUEUE_DEPTH];
    logic [RADIX_W-1:0]    r_radix_q [QUEUE_DEPTH];
    logic [PW-1:0]         r_wr_ptr;
    logic [PW-1:0]         r_rd_ptr;
    logic [CW-1:0]         r_fill;

    logic  w_push;
    logic  w_pop;
    t_kind w_kind;

    always_comb begin
        if (!(i_base inside {[RADIX_MIN:RADIX_MAX]})) begin
            w_kind = KIND_BAD;
        end else if (i_value == '0) begin
            w_kind = KIND_ZERO;
        end else begin
            w_kind = KIND_CONV;
        end
    end

    assign o_busy = (r_fill == CW'(QUEUE_DEPTH));
    assign w_push = i_start && !o_busy;
    assign w_pop  = i_pop && (r_fill != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (w_pop && !w_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_val_q[r_wr_ptr]   <= i_value;
            r_kind_q[r_wr_ptr]  <= w_kind;
            r_radix_q[r_wr_ptr] <= i_base[RADIX_W-1:0];
        end
    end

    assign o_cmd.valid = (r_fill != '0);
    assign o_cmd.kind  = r_kind_q[r_rd_ptr];
    assign o_cmd.radix = r_radix_q[r_rd_ptr];
    assign o_value     = r_val_q[r_rd_ptr];

endmodule

// ----- rtl/rdsc_back.sv -----
// Back end: bit-serial divider, digit store and most-significant-first emission.
// Depends on rdsc_pkg.
`timescale 1ns / 1ps

module rdsc_back #(
    parameter int VALUE_BITS = rdsc_pkg::VALUE_BITS_DEF,
    parameter int MAX_DIGITS = rdsc_pkg::MAX_DIGITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  rdsc_pkg::t_cmd            i_cmd,
    input  logic [VALUE_BITS-1:0]     i_value,
    output logic                      o_pop,
    output logic                      o_valid,
    output logic [rdsc_pkg::CHAR_W-1:0] o_digit_char,
    output logic                      o_last,
    output logic                      o_error
);
    import rdsc_pkg::*;

    localparam int BW = $clog2(VALUE_BITS);
    localparam int AW = $clog2(MAX_DIGITS);
    localparam int CW = $clog2(MAX_DIGITS + 1);

    logic [DIGIT_W-1:0]    r_mem [MAX_DIGITS];
    logic [DIGIT_W-1:0]    r_rd_data;

    t_state                r_state, n_state;
    logic [RADIX_W-1:0]    r_radix, n_radix;
    logic [VALUE_BITS-1:0] r_quo, n_quo;
    logic [DIGIT_W-1:0]    r_rem, n_rem;
    logic [BW-1:0]         r_bit, n_bit;
    logic [CW-1:0]         r_count, n_count;
    logic [AW-1:0]         r_idx, n_idx;
    logic                  r_valid, n_valid;
    logic [CHAR_W-1:0]     r_char, n_char;
    logic                  r_last, n_last;
    logic                  r_err, n_err;

    logic [RADIX_W-1:0]    w_partial;
    logic                  w_ge;
    logic [RADIX_W-1:0]    w_diff;
    logic [DIGIT_W-1:0]    w_rem_next;
    logic [VALUE_BITS-1:0] w_quo_next;
    logic                  w_wr_en;

    // One restoring step: bring down the next dividend bit, subtract if it fits.
    assign w_partial  = {r_rem, r_quo[VALUE_BITS-1]};
    assign w_ge       = (w_partial >= r_radix);
    assign w_diff     = w_partial - r_radix;
    assign w_rem_next = w_ge ? w_diff[DIGIT_W-1:0] : w_partial[DIGIT_W-1:0];
    assign w_quo_next = {r_quo[VALUE_BITS-2:0], w_ge};

    always_comb begin
        n_state = r_state;
        n_radix = r_radix;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_bit   = r_bit;
        n_count = r_count;
        n_idx   = r_idx;
        n_valid = 1'b0;
        n_char  = r_char;
        n_last  = r_last;
        n_err   = r_err;
        o_pop   = 1'b0;
        w_wr_en = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_cmd.valid) begin
                    o_pop = 1'b1;
                    case (i_cmd.kind)
                        KIND_BAD: begin
                            n_valid = 1'b1;
                            n_char  = CHAR_NONE;
                            n_last  = 1'b1;
                            n_err   = 1'b1;
                        end
                        KIND_ZERO: begin
                            n_valid = 1'b1;
                            n_char  = CHAR_ZERO;
                            n_last  = 1'b1;
                            n_err   = 1'b0;
                            n_quo   = '0;
                            n_count = '0;
                        end
                        default: begin
                            n_radix = i_cmd.radix;
                            n_quo   = i_value;
                            n_rem   = '0;
                            n_bit   = '0;
                            n_count = '0;
                            n_state = ST_DIV;
                        end
                    endcase
                end
            end
            ST_DIV: begin
                n_quo = w_quo_next;
                n_rem = w_rem_next;
                n_bit = r_bit + 1'b1;
                if (r_bit == BW'(VALUE_BITS - 1)) begin
                    // Division finished: store the remainder as the next digit.
                    w_wr_en = 1'b1;
                    n_count = r_count + 1'b1;
                    n_rem   = '0;
                    n_bit   = '0;
                    if (w_quo_next == '0 || r_count == CW'(MAX_DIGITS - 1)) begin
                        n_idx   = r_count[AW-1:0];
                        n_state = ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                n_valid = 1'b1;
                n_char  = glyph(r_rd_data);
                n_last  = (r_idx == '0);
                n_err   = 1'b0;
                if (r_idx == '0) begin
                    n_state = ST_IDLE;
                end else begin
                    n_idx   = r_idx - 1'b1;
                    n_state = ST_FETCH;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
            r_quo   <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_quo   <= n_quo;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_radix <= n_radix;
        r_rem   <= n_rem;
        r_bit   <= n_bit;
        r_idx   <= n_idx;
        r_char  <= n_char;
        r_last  <= n_last;
        r_err   <= n_err;
    end

    // Digit store: one write port for the divider, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_count[AW-1:0]] <= w_rem_next;
        end
        r_rd_data <= r_mem[r_idx];
    end

    assign o_valid      = r_valid;
    assign o_digit_char = r_char;
    assign o_last       = r_last;
    assign o_error      = r_err;

endmodule

// ----- rtl/radix_digit_string_converter.sv -----
// Top level of the radix digit string converter.
// Depends on rdsc_pkg, rdsc_front and rdsc_back.
`timescale 1ns / 1ps

// Converts a non-negative value to its digit string in a base from 2 to 16.
// A request transfers at a rising edge with i_start high and o_busy low; a
// two-entry command queue sits behind the port, so up to two requests can be
// taken while an earlier one is still being converted, and o_busy rises only
// when that queue is full. Results leave as one-cycle strobes on o_valid and
// must be taken when shown, since there is no way to hold them off. Each
// digit is an ASCII character '0'-'9' or 'A'-'F', most significant first, and
// o_last marks the final one. A zero value gives the single character '0'.
// A base of 0, 1 or above 16 gives one result with o_error and o_last set and
// a zero character. The back end runs the shared bit-serial divider once for
// each digit; it retires one quotient bit per cycle and stores the remainder
// as the digit. Once all digits are stored, each is read from the digit
// store and emitted, most significant first. The default value width is 31
// bits. Zero and bad-base requests are answered from the idle state without
// the divider. If a value needs more than MAX_DIGITS digits only the least
// significant MAX_DIGITS are emitted.
module radix_digit_string_converter #(
    parameter int VALUE_BITS = rdsc_pkg::VALUE_BITS_DEF,
    parameter int MAX_DIGITS = rdsc_pkg::MAX_DIGITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic [VALUE_BITS-1:0]       i_value,
    input  logic [rdsc_pkg::BASE_W-1:0] i_base,
    output logic                        o_valid,
    output logic [rdsc_pkg::CHAR_W-1:0] o_digit_char,
    output logic                        o_last,
    output logic                        o_error
);
    import rdsc_pkg::*;

    // Command handed from the queue head to the back end.
    t_cmd                  w_cmd;
    logic [VALUE_BITS-1:0] w_value;
    logic                  w_pop;

    // The front end classifies each request as bad base, zero or a real
    // conversion, so the back end never has to look at the raw base field.
    rdsc_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_value (i_value),
        .i_base  (i_base),
        .o_busy  (o_busy),
        .o_cmd   (w_cmd),
        .o_value (w_value),
        .i_pop   (w_pop)
    );

    // The back end pops one command at a time and runs it to completion.
    rdsc_back #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_value      (w_value),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .o_digit_char (o_digit_char),
        .o_last       (o_last),
        .o_error      (o_error)
    );

endmodule

// ----- rtl/rdsc_checker.sv -----
// Port-level checks on the radix converter's result stream, bound to the top.
// Depends on assert_macros.svh and radix_digit_string_converter.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rdsc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_busy,
    input logic       o_valid,
    input logic [7:0] o_digit_char,
    input logic       o_last,
    input logic       o_error
);

    `ASSERT_RST(a_reset_quiet, !i_rst_n |=> !o_valid && !o_busy, "outputs active after reset")
    `ASSERT_CLK(a_error_single, o_valid && o_error |-> o_last && o_digit_char == 8'h00, "bad error result")
    `ASSERT_CLK(a_digit_glyph, o_valid && !o_error |-> (o_digit_char >= 8'h30 && o_digit_char <= 8'h39) || (o_digit_char >= 8'h41 && o_digit_char <= 8'h46), "result is not a digit")
    `ASSERT_CLK(a_digit_gap, o_valid && !o_last |=> !o_valid, "digits not spaced by the store read")

endmodule

bind radix_digit_string_converter rdsc_checker u_rdsc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_busy       (o_busy),
    .o_valid      (o_valid),
    .o_digit_char (o_digit_char),
    .o_last       (o_last),
    .o_error      (o_error)
);
